@@ rtl/core/ring_scratch_allocator_assert.svh @@
// assertion macros for the ring scratch allocator
// used by files that take clk_i and rst_ni as their clock and reset
`ifndef RING_SCRATCH_ALLOCATOR_ASSERT_SVH
`define RING_SCRATCH_ALLOCATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define RSA_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// condition holds in the same cycle as the trigger
`define RSA_ASSERT_IMPL(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define RSA_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) else $error(msg);

`endif

@@ rtl/core/rsa_pkg.sv @@
// shared types and constants for the ring scratch allocator
// no dependencies
package rsa_pkg;

  localparam int RING_WORDS_DEF = 1024;
  localparam int ALU_W          = 32;

  typedef logic [ALU_W-1:0] word_t;

  localparam word_t PAD_WORD = 32'hFFFF_FFFF;

  // one operation of the shared adder
  typedef struct packed {
    word_t a;
    word_t b;
    logic  sub;
  } alu_req_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_RING     = 2'd0,
    ST_BACKING  = 2'd1,
    ST_NULL     = 2'd2,
    ST_FREE_FWD = 2'd3
  } status_e;

endpackage

@@ rtl/core/rsa_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module rsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rsa_alu.sv @@
// shared add / subtract unit of the ring scratch allocator
// depends on rsa_pkg
module rsa_alu (
  input  rsa_pkg::alu_req_t req_i,
  output rsa_pkg::word_t    sum_o,
  output logic              ge_o    // a >= b, meaningful for subtract
);

  logic [rsa_pkg::ALU_W:0] full;
  rsa_pkg::word_t          b_op;

  always_comb begin
    b_op  = req_i.sub ? ~req_i.b : req_i.b;
    full  = {1'b0, req_i.a} + {1'b0, b_op} + {{rsa_pkg::ALU_W{1'b0}}, req_i.sub};
    sum_o = full[rsa_pkg::ALU_W-1:0];
    ge_o  = full[rsa_pkg::ALU_W] & req_i.sub;
  end

endmodule

@@ rtl/core/ring_scratch_allocator.sv @@
// top level of the ring scratch allocator: sequencer, offsets and result stage
// depends on rsa_pkg, rsa_alu, rsa_ram and ring_scratch_allocator_assert.svh
//
// Ring-buffer scratch allocator over a word store of RING_WORDS 32-bit words.
// An allocate request writes a header word (total block bytes) at the tail,
// all-ones pad words up to the aligned data offset, and returns that offset;
// when the block would run past the end of the ring the leftover part is
// marked free and the block restarts at offset 0, and when it would meet the
// live region the request is sent to the backing allocator (status 1).
// A zero size gives status 2; a free at or above capacity gives status 3.
// A free walks back over pad words to the header, sets its bit 31, then moves
// head past consecutive free blocks. Each request gets exactly one response.
// All offset arithmetic goes through one shared 32-bit adder stepped by the
// sequencer, and the store has one read and one write port, so a request
// is worked through in steps and the input is not ready until the response
// has been loaded into the output register:
//   allocate: size, data offset, end, capacity and head checks, header,
//   then pad words one at a time (up to 3); a wrap marks the leftover free
//   and repeats the end and capacity checks; a refused allocate stops after
//   the fit decision, a zero size after the size step
//   free: capacity check, walk over pad words, header write, then a head
//   walk over free blocks (bounded at RING_WORDS blocks) that stops on a
//   header that is not a usable free block or on an empty ring
// The output register lets the next request start while a response still
// waits. The capacity register may be written only while the block is idle;
// a write also empties the ring. No clearing pass is needed after reset.
`include "ring_scratch_allocator_assert.svh"

module ring_scratch_allocator #(
  parameter int RING_WORDS = rsa_pkg::RING_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // size_bytes[23:0], align[28:24], address[60:29]
  input  logic        s_axis_tuser_i,   // opcode[0]
  // response channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // data_address[11:0]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  // capacity register
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i       // capacity_bytes
);

  // widths that follow from the ring depth
  localparam int WIDX  = $clog2(RING_WORDS);        // word index
  localparam int MAXC  = RING_WORDS * 4;            // largest capacity in bytes
  localparam int OW    = $clog2(MAXC + 1);          // byte offset, holds capacity
  localparam int CW    = (OW > 14) ? OW : 14;       // capacity rounding
  localparam int NW    = $clog2(RING_WORDS + 1);    // head walk step count
  localparam int CAP_RST = (MAXC < 4096) ? MAXC : 4096;

  typedef enum logic [4:0] {
    S_IDLE,
    S_AL_SIZE,   // round size up to words
    S_AL_DATA,   // aligned data offset
    S_AL_END,    // block end
    S_AL_CMP,    // end against capacity, decides wrap
    S_AL_WRAP,   // mark leftover free, restart at 0
    S_AL_HEAD,   // end against head
    S_AL_FIT,    // tail against head, fit decision
    S_AL_HDR,    // header write
    S_AL_PADI,   // first pad offset
    S_AL_PAD,    // pad writes
    S_FR_CAP,    // address against capacity
    S_FR_RD,     // read the word below the walk pointer
    S_FR_CHK,    // pad or header
    S_HW_RD,     // read the header at head
    S_HW_CHK,    // check a free block
    S_HW_ADD,    // advance head
    S_OUT        // load the response register
  } state_e;

  state_e              state_q;

  // request payload
  logic [23:0]         size_q;
  logic [4:0]          align_q;
  rsa_pkg::word_t      addr_q;

  // working registers
  rsa_pkg::word_t      s4_q;
  rsa_pkg::word_t      d_q;
  rsa_pkg::word_t      p_q;
  logic [OW-1:0]       h_q;
  logic [OW-1:0]       q_q;
  logic                wrapped_q;
  logic                pgec_q;      // end reaches capacity
  logic                pgeh_q;      // end reaches head
  logic [WIDX-1:0]     w_q;
  logic [WIDX-1:0]     wm1_q;
  logic [OW-1:0]       room_q;
  logic [OW-1:0]       len_q;
  logic [NW-1:0]       n_q;

  // ring state
  logic [OW-1:0]       cap_q;
  logic [OW-1:0]       head_q;
  logic [OW-1:0]       tail_q;

  // response
  rsa_pkg::status_e    res_status_q;
  logic [11:0]         res_addr_q;
  logic                m_valid_q;
  rsa_pkg::status_e    m_status_q;
  logic [11:0]         m_addr_q;

  // shared adder
  rsa_pkg::alu_req_t   alu_req;
  rsa_pkg::word_t      alu_sum;
  logic                alu_ge;

  // store ports
  logic                ram_we;
  logic [WIDX-1:0]     ram_waddr;
  rsa_pkg::word_t      ram_wdata;
  logic                ram_re;
  logic [WIDX-1:0]     ram_raddr;
  rsa_pkg::word_t      ram_rdata;

  // decoded values
  rsa_pkg::word_t      a_val;
  rsa_pkg::word_t      len_w;
  logic                empty;
  logic                fail;
  logic                hdr_ok;
  logic                s_accept;
  logic [CW-1:0]       cap_round;
  logic [CW-1:0]       cap_eff;

  rsa_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  rsa_ram #(
    .WIDTH (rsa_pkg::ALU_W),
    .DEPTH (RING_WORDS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {4'b0000, m_addr_q};

  // alignment: 16 and above, 8 to 15, else 4
  always_comb begin
    if (align_q[4]) begin
      a_val = rsa_pkg::word_t'(16);
    end else if (align_q[3]) begin
      a_val = rsa_pkg::word_t'(8);
    end else begin
      a_val = rsa_pkg::word_t'(4);
    end
  end

  // capacity rounded up to words and clamped to the store
  always_comb begin
    cap_round = (CW'(cfg_wdata_i) + CW'(3)) & ~CW'(3);
    if (cap_round == '0) begin
      cap_eff = CW'(4);
    end else if (cap_round > CW'(MAXC)) begin
      cap_eff = CW'(MAXC);
    end else begin
      cap_eff = cap_round;
    end
  end

  assign empty  = (head_q == tail_q);
  assign len_w  = {1'b0, ram_rdata[30:0]};
  // free header with a usable length that stays inside the ring
  assign hdr_ok = ram_rdata[31] && (len_w != '0) && (ram_rdata[1:0] == 2'b00) && alu_ge;

  // fit decision, alu_ge holds tail >= head here
  always_comb begin
    if (empty) begin
      fail = pgec_q | (wrapped_q & pgeh_q);
    end else if (alu_ge) begin
      fail = (wrapped_q & pgeh_q) |
             (!wrapped_q && (p_q == rsa_pkg::word_t'(cap_q)) && (head_q == '0));
    end else begin
      fail = wrapped_q | pgeh_q;
    end
  end

  // operand selection and store access per step
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = h_q[WIDX+1:2];
    ram_wdata   = rsa_pkg::PAD_WORD;
    ram_re      = 1'b0;
    ram_raddr   = head_q[WIDX+1:2];
    unique case (state_q)
      S_AL_SIZE: begin
        alu_req.a = rsa_pkg::word_t'(size_q);
        alu_req.b = rsa_pkg::word_t'(3);
      end
      S_AL_DATA: begin
        alu_req.a = rsa_pkg::word_t'(tail_q);
        alu_req.b = a_val + rsa_pkg::word_t'(3);
      end
      S_AL_END: begin
        alu_req.a = d_q;
        alu_req.b = s4_q;
      end
      S_AL_CMP: begin
        alu_req.a   = p_q;
        alu_req.b   = rsa_pkg::word_t'(cap_q);
        alu_req.sub = 1'b1;
      end
      S_AL_WRAP: begin
        alu_req.a   = rsa_pkg::word_t'(cap_q);
        alu_req.b   = rsa_pkg::word_t'(h_q);
        alu_req.sub = 1'b1;
        ram_we      = 1'b1;
        ram_wdata   = {1'b1, alu_sum[30:0]};
      end
      S_AL_HEAD: begin
        alu_req.a   = p_q;
        alu_req.b   = rsa_pkg::word_t'(head_q);
        alu_req.sub = 1'b1;
      end
      S_AL_FIT: begin
        alu_req.a   = rsa_pkg::word_t'(tail_q);
        alu_req.b   = rsa_pkg::word_t'(head_q);
        alu_req.sub = 1'b1;
      end
      S_AL_HDR: begin
        alu_req.a   = p_q;
        alu_req.b   = rsa_pkg::word_t'(h_q);
        alu_req.sub = 1'b1;
        ram_we      = 1'b1;
        ram_wdata   = alu_sum;
      end
      S_AL_PADI: begin
        alu_req.a = rsa_pkg::word_t'(h_q);
        alu_req.b = rsa_pkg::word_t'(4);
      end
      S_AL_PAD: begin
        alu_req.a = rsa_pkg::word_t'(q_q);
        alu_req.b = rsa_pkg::word_t'(4);
        ram_we    = (rsa_pkg::word_t'(q_q) != d_q);
        ram_waddr = q_q[WIDX+1:2];
      end
      S_FR_CAP: begin
        alu_req.a   = addr_q;
        alu_req.b   = rsa_pkg::word_t'(cap_q);
        alu_req.sub = 1'b1;
      end
      S_FR_RD: begin
        alu_req.a   = rsa_pkg::word_t'(w_q);
        alu_req.b   = rsa_pkg::word_t'(1);
        alu_req.sub = 1'b1;
        ram_re      = (w_q != '0);
        ram_raddr   = alu_sum[WIDX-1:0];
      end
      S_FR_CHK: begin
        ram_we    = (ram_rdata != rsa_pkg::PAD_WORD);
        ram_waddr = wm1_q;
        ram_wdata = {1'b1, ram_rdata[30:0]};
      end
      S_HW_RD: begin
        alu_req.a   = rsa_pkg::word_t'(cap_q);
        alu_req.b   = rsa_pkg::word_t'(head_q);
        alu_req.sub = 1'b1;
        ram_re      = (n_q != NW'(RING_WORDS)) && !empty;
      end
      S_HW_CHK: begin
        alu_req.a   = rsa_pkg::word_t'(room_q);
        alu_req.b   = len_w;
        alu_req.sub = 1'b1;
      end
      S_HW_ADD: begin
        alu_req.a = rsa_pkg::word_t'(head_q);
        alu_req.b = rsa_pkg::word_t'(len_q);
      end
      S_IDLE, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, ring offsets and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      size_q       <= '0;
      align_q      <= '0;
      addr_q       <= '0;
      s4_q         <= '0;
      d_q          <= '0;
      p_q          <= '0;
      h_q          <= '0;
      q_q          <= '0;
      wrapped_q    <= 1'b0;
      pgec_q       <= 1'b0;
      pgeh_q       <= 1'b0;
      w_q          <= '0;
      wm1_q        <= '0;
      room_q       <= '0;
      len_q        <= '0;
      n_q          <= '0;
      cap_q        <= OW'(CAP_RST);
      head_q       <= '0;
      tail_q       <= '0;
      res_status_q <= rsa_pkg::ST_RING;
      res_addr_q   <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= rsa_pkg::ST_RING;
      m_addr_q     <= '0;
    end else begin
      // response taken: register frees up, unless the output step refills it
      if (m_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            size_q     <= s_axis_tdata_i[23:0];
            align_q    <= s_axis_tdata_i[28:24];
            addr_q     <= s_axis_tdata_i[60:29];
            res_status_q <= rsa_pkg::ST_RING;
            res_addr_q <= '0;
            if (s_axis_tuser_i == rsa_pkg::OP_FREE) begin
              state_q <= S_FR_CAP;
            end else begin
              state_q <= S_AL_SIZE;
            end
          end
        end

        S_AL_SIZE: begin
          wrapped_q <= 1'b0;
          if (size_q == '0) begin
            res_status_q <= rsa_pkg::ST_NULL;
            state_q      <= S_OUT;
          end else begin
            s4_q    <= alu_sum & ~rsa_pkg::word_t'(3);
            state_q <= S_AL_DATA;
          end
        end

        S_AL_DATA: begin
          d_q     <= alu_sum & ~(a_val - rsa_pkg::word_t'(1));
          h_q     <= tail_q;
          state_q <= S_AL_END;
        end

        S_AL_END: begin
          p_q     <= alu_sum;
          state_q <= S_AL_CMP;
        end

        S_AL_CMP: begin
          pgec_q <= alu_ge;
          // past the end of the ring: wrap once
          if (!wrapped_q && alu_ge && (p_q != rsa_pkg::word_t'(cap_q))) begin
            state_q <= S_AL_WRAP;
          end else begin
            state_q <= S_AL_HEAD;
          end
        end

        S_AL_WRAP: begin
          h_q       <= '0;
          d_q       <= a_val;
          wrapped_q <= 1'b1;
          state_q   <= S_AL_END;
        end

        S_AL_HEAD: begin
          pgeh_q  <= alu_ge;
          state_q <= S_AL_FIT;
        end

        S_AL_FIT: begin
          if (fail) begin
            res_status_q <= rsa_pkg::ST_BACKING;
            state_q      <= S_OUT;
          end else begin
            state_q <= S_AL_HDR;
          end
        end

        S_AL_HDR: begin
          state_q <= S_AL_PADI;
        end

        S_AL_PADI: begin
          q_q     <= alu_sum[OW-1:0];
          state_q <= S_AL_PAD;
        end

        S_AL_PAD: begin
          if (rsa_pkg::word_t'(q_q) == d_q) begin
            // a tail that reaches capacity is kept as 0
            tail_q       <= pgec_q ? '0 : p_q[OW-1:0];
            res_status_q <= rsa_pkg::ST_RING;
            res_addr_q   <= d_q[11:0];
            state_q      <= S_OUT;
          end else begin
            q_q <= alu_sum[OW-1:0];
          end
        end

        S_FR_CAP: begin
          n_q <= '0;
          if (alu_ge) begin
            res_status_q <= rsa_pkg::ST_FREE_FWD;
            state_q      <= S_OUT;
          end else begin
            w_q     <= addr_q[WIDX+1:2];
            state_q <= S_FR_RD;
          end
        end

        S_FR_RD: begin
          // walked down to offset 0 without a header: nothing to free
          if (w_q == '0) begin
            state_q <= S_OUT;
          end else begin
            wm1_q   <= alu_sum[WIDX-1:0];
            state_q <= S_FR_CHK;
          end
        end

        S_FR_CHK: begin
          if (ram_rdata == rsa_pkg::PAD_WORD) begin
            w_q     <= wm1_q;
            state_q <= S_FR_RD;
          end else begin
            state_q <= S_HW_RD;
          end
        end

        S_HW_RD: begin
          if ((n_q == NW'(RING_WORDS)) || empty) begin
            state_q <= S_OUT;
          end else begin
            room_q  <= alu_sum[OW-1:0];
            state_q <= S_HW_CHK;
          end
        end

        S_HW_CHK: begin
          if (!hdr_ok) begin
            state_q <= S_OUT;
          end else begin
            n_q <= n_q + NW'(1);
            if (len_w == rsa_pkg::word_t'(room_q)) begin
              head_q  <= '0;
              state_q <= S_HW_RD;
            end else begin
              len_q   <= len_w[OW-1:0];
              state_q <= S_HW_ADD;
            end
          end
        end

        S_HW_ADD: begin
          head_q  <= alu_sum[OW-1:0];
          state_q <= S_HW_RD;
        end

        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q  <= 1'b1;
            m_status_q <= res_status_q;
            m_addr_q   <= res_addr_q;
            state_q    <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // capacity write empties the ring
      if (cfg_we_i) begin
        cap_q  <= cap_eff[OW-1:0];
        head_q <= '0;
        tail_q <= '0;
      end
    end
  end

  `RSA_ASSERT_HOLDS(a_offsets_in_ring, (head_q < cap_q) && (tail_q < cap_q), "offset out of ring")
  `RSA_ASSERT_IMPL(a_write_in_ring, ram_we, OW'({ram_waddr, 2'b00}) < cap_q, "write out of ring")
  `RSA_ASSERT_NEXT(a_accept_starts_work, s_accept, state_q != S_IDLE, "request not started")
  `RSA_ASSERT_HOLDS(a_walk_bounded, n_q <= NW'(RING_WORDS), "head walk ran past the store")

endmodule
